/* hw/rtl/css_lex_pkg.sv */
// Shared types, token kind codes and character classes of the CSS lexer.
package css_lex_pkg;

    // Lexer mode between bytes.
    typedef enum logic [3:0] {
        M_IDLE     = 4'd0,
        M_SPACE    = 4'd1,
        M_SLASH    = 4'd2,
        M_COMMENT  = 4'd3,
        M_STRING   = 4'd4,
        M_HASH     = 4'd5,
        M_AT_WAIT  = 4'd6,
        M_AT_NAME  = 4'd7,
        M_SIGN     = 4'd8,
        M_SIGN_DOT = 4'd9,
        M_DOT      = 4'd10,
        M_INT      = 4'd11,
        M_INT_DOT  = 4'd12,
        M_FRAC     = 4'd13,
        M_DIM      = 4'd14,
        M_NAME     = 4'd15
    } t_mode;

    // Token kind codes.
    localparam logic [4:0] K_EOF       = 5'd0;
    localparam logic [4:0] K_SPACE     = 5'd1;
    localparam logic [4:0] K_LBRACE    = 5'd2;
    localparam logic [4:0] K_RBRACE    = 5'd3;
    localparam logic [4:0] K_COLON     = 5'd4;
    localparam logic [4:0] K_SEMI      = 5'd5;
    localparam logic [4:0] K_COMMA     = 5'd6;
    localparam logic [4:0] K_LPAREN    = 5'd7;
    localparam logic [4:0] K_RPAREN    = 5'd8;
    localparam logic [4:0] K_LBRACKET  = 5'd9;
    localparam logic [4:0] K_RBRACKET  = 5'd10;
    localparam logic [4:0] K_STRING    = 5'd11;
    localparam logic [4:0] K_HASH      = 5'd12;
    localparam logic [4:0] K_AT        = 5'd13;
    localparam logic [4:0] K_DELIM     = 5'd14;
    localparam logic [4:0] K_NUMBER    = 5'd15;
    localparam logic [4:0] K_PERCENT   = 5'd16;
    localparam logic [4:0] K_DIMENSION = 5'd17;
    localparam logic [4:0] K_FUNCTION  = 5'd18;
    localparam logic [4:0] K_IDENT     = 5'd19;

    // Symbol value that stands for the end of the text.
    localparam logic [8:0] SYM_END = 9'h100;

    // Characters with a role in the grammar.
    localparam logic [7:0] C_BSLASH = 8'h5C;
    localparam logic [7:0] C_AT     = 8'h40;
    localparam logic [7:0] C_HASH   = 8'h23;
    localparam logic [7:0] C_PCT    = 8'h25;
    localparam logic [7:0] C_SLASH  = 8'h2F;
    localparam logic [7:0] C_STAR   = 8'h2A;
    localparam logic [7:0] C_DQUOTE = 8'h22;
    localparam logic [7:0] C_SQUOTE = 8'h27;
    localparam logic [7:0] C_DOT    = 8'h2E;
    localparam logic [7:0] C_PLUS   = 8'h2B;
    localparam logic [7:0] C_MINUS  = 8'h2D;
    localparam logic [7:0] C_LPAREN = 8'h28;

    // Control state carried from byte to byte.
    typedef struct packed {
        t_mode      mode;
        logic       la_vld;
        logic [7:0] la0;
        logic [7:0] quote;
        logic       esc;
    } t_ctl;

    // One result token, offsets already cut to 32 bits.
    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] vs;
        logic [31:0] ve;
        logic [31:0] uo;
        logic [7:0]  delim;
    } t_tok;

    // All tokens caused by one input item.
    typedef struct packed {
        t_tok [3:0] tok;
        logic [2:0] cnt;
    } t_bundle;

    function automatic logic is_space(input logic [8:0] b);
        return (b == 9'h020) || ((b >= 9'h009) && (b <= 9'h00D));
    endfunction

    function automatic logic is_digit(input logic [8:0] b);
        return (b >= 9'h030) && (b <= 9'h039);
    endfunction

    function automatic logic name_start(input logic [8:0] b);
        return ((b >= 9'h061) && (b <= 9'h07A)) || ((b >= 9'h041) && (b <= 9'h05A))
            || (b == 9'h05F) || (b == {1'b0, C_MINUS});
    endfunction

    function automatic logic name_char(input logic [8:0] b);
        return name_start(b) || is_digit(b);
    endfunction

    // Punctuation kind of a byte, K_EOF when it is none.
    function automatic logic [4:0] punct_kind(input logic [8:0] b);
        logic [4:0] k;
        unique case (b)
            9'h07B:  k = K_LBRACE;
            9'h07D:  k = K_RBRACE;
            9'h03A:  k = K_COLON;
            9'h03B:  k = K_SEMI;
            9'h02C:  k = K_COMMA;
            9'h028:  k = K_LPAREN;
            9'h029:  k = K_RPAREN;
            9'h05B:  k = K_LBRACKET;
            9'h05D:  k = K_RBRACKET;
            default: k = K_EOF;
        endcase
        return k;
    endfunction

endpackage

/* hw/rtl/css_lex_phase.sv */
// One resolution step of the lexer: handles one mode against one symbol.
module css_lex_phase
    import css_lex_pkg::*;
#(
    parameter int OB = 32
) (
    input  logic          i_run,
    input  t_ctl          i_ctl,
    input  logic [OB-1:0] i_tb,
    input  logic [OB-1:0] i_ub,
    input  logic [8:0]    i_b,
    input  logic [OB-1:0] i_p,
    output t_ctl          o_ctl,
    output logic [OB-1:0] o_tb,
    output logic [OB-1:0] o_ub,
    output logic          o_emit,
    output t_tok          o_tok,
    output logic          o_cont
);

    logic [OB-1:0] p1;
    logic [OB-1:0] pm1;
    logic [OB-1:0] tb1;
    logic [4:0]    pk;

    function automatic t_tok mk(input logic [4:0] k, input logic [OB-1:0] vs,
                                input logic [OB-1:0] ve, input logic [OB-1:0] uo,
                                input logic [7:0] d);
        t_tok t;
        t.kind  = k;
        t.vs    = 32'(vs);
        t.ve    = 32'(ve);
        t.uo    = 32'(uo);
        t.delim = d;
        return t;
    endfunction

    assign p1  = i_p + OB'(1);
    assign pm1 = i_p - OB'(1);
    assign tb1 = i_tb + OB'(1);
    assign pk  = punct_kind(i_b);

    // Mode handling; a step either stops or hands the symbol to the next step.
    always_comb begin
        o_ctl  = i_ctl;
        o_tb   = i_tb;
        o_ub   = i_ub;
        o_emit = 1'b0;
        o_tok  = '0;
        o_cont = 1'b0;
        if (i_run) begin
            unique case (i_ctl.mode)
                M_IDLE: begin
                    if (!i_b[8]) begin
                        o_tb = i_p;
                        if (is_space(i_b)) begin
                            o_ctl.mode = M_SPACE;
                        end else if (i_b[7:0] == C_SLASH) begin
                            o_ctl.mode = M_SLASH;
                        end else if (pk != K_EOF) begin
                            o_emit = 1'b1;
                            o_tok  = mk(pk, i_p, p1, p1, 8'h00);
                        end else if (i_b[7:0] == C_DQUOTE || i_b[7:0] == C_SQUOTE) begin
                            o_ctl.mode  = M_STRING;
                            o_ctl.quote = i_b[7:0];
                            o_ctl.esc   = 1'b0;
                            o_tb        = p1;
                        end else if (i_b[7:0] == C_HASH) begin
                            o_ctl.mode = M_HASH;
                            o_tb       = p1;
                        end else if (i_b[7:0] == C_AT) begin
                            o_ctl.mode = M_AT_WAIT;
                        end else if (is_digit(i_b)) begin
                            o_ctl.mode = M_INT;
                        end else if (i_b[7:0] == C_DOT) begin
                            o_ctl.mode = M_DOT;
                        end else if (i_b[7:0] == C_PLUS || i_b[7:0] == C_MINUS) begin
                            o_ctl.mode   = M_SIGN;
                            o_ctl.la0    = i_b[7:0];
                            o_ctl.la_vld = 1'b1;
                        end else if (name_start(i_b)) begin
                            o_ctl.mode = M_NAME;
                        end else begin
                            o_emit = 1'b1;
                            o_tok  = mk(K_DELIM, i_p, p1, p1, i_b[7:0]);
                        end
                    end
                end
                M_SPACE: begin
                    if (!is_space(i_b)) begin
                        o_emit     = 1'b1;
                        o_tok      = mk(K_SPACE, i_tb, i_p, i_p, 8'h00);
                        o_ctl.mode = M_IDLE;
                        o_cont     = 1'b1;
                    end
                end
                M_SLASH: begin
                    if (i_b == {1'b0, C_STAR}) begin
                        o_ctl.mode   = M_COMMENT;
                        o_ctl.la_vld = 1'b0;
                    end else begin
                        o_emit     = 1'b1;
                        o_tok      = mk(K_DELIM, i_tb, tb1, tb1, C_SLASH);
                        o_ctl.mode = M_IDLE;
                        o_cont     = 1'b1;
                    end
                end
                M_COMMENT: begin
                    if (i_ctl.la_vld && i_ctl.la0 == C_STAR && i_b == {1'b0, C_SLASH}) begin
                        o_ctl.mode   = M_IDLE;
                        o_ctl.la_vld = 1'b0;
                    end else begin
                        o_ctl.la0    = i_b[7:0];
                        o_ctl.la_vld = 1'b1;
                    end
                end
                M_STRING: begin
                    if (i_ctl.esc) begin
                        o_ctl.esc = 1'b0;
                    end else if (i_b == {1'b0, i_ctl.quote}) begin
                        o_emit     = 1'b1;
                        o_tok      = mk(K_STRING, i_tb, i_p, i_p, 8'h00);
                        o_ctl.mode = M_IDLE;
                    end else if (i_b == {1'b0, C_BSLASH}) begin
                        o_ctl.esc = 1'b1;
                    end
                end
                M_HASH: begin
                    if (!name_char(i_b)) begin
                        o_emit     = 1'b1;
                        o_tok      = mk(K_HASH, i_tb, i_p, i_p, 8'h00);
                        o_ctl.mode = M_IDLE;
                        o_cont     = 1'b1;
                    end
                end
                M_AT_WAIT: begin
                    if (name_start(i_b)) begin
                        o_ctl.mode = M_AT_NAME;
                        o_tb       = i_p;
                    end else begin
                        o_emit     = 1'b1;
                        o_tok      = mk(K_DELIM, i_tb, tb1, tb1, C_AT);
                        o_ctl.mode = M_IDLE;
                        o_cont     = 1'b1;
                    end
                end
                M_AT_NAME: begin
                    if (!name_char(i_b)) begin
                        o_emit     = 1'b1;
                        o_tok      = mk(K_AT, i_tb, i_p, i_p, 8'h00);
                        o_ctl.mode = M_IDLE;
                        o_cont     = 1'b1;
                    end
                end
                M_SIGN: begin
                    o_ctl.la_vld = 1'b0;
                    if (is_digit(i_b)) begin
                        o_ctl.mode = M_INT;
                    end else if (i_b == {1'b0, C_DOT}) begin
                        o_ctl.mode   = M_SIGN_DOT;
                        o_ctl.la_vld = 1'b1;
                    end else if (i_ctl.la0 == C_PLUS) begin
                        // A plus sign that starts no number is a delim.
                        o_emit     = 1'b1;
                        o_tok      = mk(K_DELIM, i_tb, tb1, tb1, C_PLUS);
                        o_ctl.mode = M_IDLE;
                        o_cont     = 1'b1;
                    end else begin
                        // A minus sign that starts no number opens a name.
                        o_ctl.mode = M_NAME;
                        o_cont     = 1'b1;
                    end
                end
                M_SIGN_DOT: begin
                    o_ctl.la_vld = 1'b0;
                    if (is_digit(i_b)) begin
                        o_ctl.mode = M_FRAC;
                    end else begin
                        // The sign resolves, then the held dot starts its own token.
                        o_emit = 1'b1;
                        if (i_ctl.la0 == C_PLUS) begin
                            o_tok = mk(K_DELIM, i_tb, tb1, tb1, C_PLUS);
                        end else begin
                            o_tok = mk(K_IDENT, i_tb, pm1, pm1, 8'h00);
                        end
                        o_ctl.mode = M_DOT;
                        o_tb       = pm1;
                        o_cont     = 1'b1;
                    end
                end
                M_DOT: begin
                    if (is_digit(i_b)) begin
                        o_ctl.mode = M_FRAC;
                    end else begin
                        o_emit     = 1'b1;
                        o_tok      = mk(K_DELIM, i_tb, tb1, tb1, C_DOT);
                        o_ctl.mode = M_IDLE;
                        o_cont     = 1'b1;
                    end
                end
                M_INT, M_FRAC: begin
                    if (is_digit(i_b)) begin
                        o_ctl.mode = i_ctl.mode;
                    end else if (i_b == {1'b0, C_DOT} && i_ctl.mode == M_INT) begin
                        o_ctl.mode   = M_INT_DOT;
                        o_ctl.la0    = C_DOT;
                        o_ctl.la_vld = 1'b1;
                    end else if (i_b == {1'b0, C_PCT}) begin
                        o_emit     = 1'b1;
                        o_tok      = mk(K_PERCENT, i_tb, p1, p1, 8'h00);
                        o_ctl.mode = M_IDLE;
                    end else if (name_start(i_b)) begin
                        o_ctl.mode = M_DIM;
                        o_ub       = i_p;
                    end else begin
                        o_emit     = 1'b1;
                        o_tok      = mk(K_NUMBER, i_tb, i_p, i_p, 8'h00);
                        o_ctl.mode = M_IDLE;
                        o_cont     = 1'b1;
                    end
                end
                M_INT_DOT: begin
                    o_ctl.la_vld = 1'b0;
                    if (is_digit(i_b)) begin
                        o_ctl.mode = M_FRAC;
                    end else begin
                        o_emit     = 1'b1;
                        o_tok      = mk(K_NUMBER, i_tb, pm1, pm1, 8'h00);
                        o_ctl.mode = M_DOT;
                        o_tb       = pm1;
                        o_cont     = 1'b1;
                    end
                end
                M_DIM: begin
                    if (!name_char(i_b)) begin
                        o_emit     = 1'b1;
                        o_tok      = mk(K_DIMENSION, i_tb, i_p, i_ub, 8'h00);
                        o_ctl.mode = M_IDLE;
                        o_cont     = 1'b1;
                    end
                end
                M_NAME: begin
                    if (i_b == {1'b0, C_LPAREN}) begin
                        o_emit     = 1'b1;
                        o_tok      = mk(K_FUNCTION, i_tb, i_p, i_p, 8'h00);
                        o_ctl.mode = M_IDLE;
                    end else if (!name_char(i_b)) begin
                        o_emit     = 1'b1;
                        o_tok      = mk(K_IDENT, i_tb, i_p, i_p, 8'h00);
                        o_ctl.mode = M_IDLE;
                        o_cont     = 1'b1;
                    end
                end
            endcase
        end
    end

endmodule

/* hw/rtl/css_lex_outq.sv */
// Two-entry queue of token groups, drained one token per request.
module css_lex_outq
    import css_lex_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_bundle,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_tok    o_tok,
    output logic    o_last
);

    t_bundle    r_buf [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic [1:0] r_idx;
    logic       pop_tok;
    logic       pop_grp;
    t_bundle    head;

    assign head    = r_buf[r_rd];
    assign o_valid = (r_cnt != 2'd0);
    assign o_tok   = head.tok[r_idx];
    assign o_last  = ({1'b0, r_idx} == (head.cnt - 3'd1));
    assign o_room  = (r_cnt != 2'd2);
    assign pop_tok = o_valid && i_ready;
    assign pop_grp = pop_tok && o_last;

    // Group storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_bundle;
        end
    end

    // Pointers, fill count and token index inside the head group.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
            r_idx <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (pop_grp) begin
                r_rd  <= ~r_rd;
                r_idx <= 2'd0;
            end else if (pop_tok) begin
                r_idx <= r_idx + 2'd1;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, pop_grp};
        end
    end

endmodule

/* hw/rtl/css_token_lexer_top.sv */
// Flow: an accepted byte or end marker is held in the input register, then its tokens are written
// into the token queue, which offers the first of them; a full queue stalls that write.
// Throughput: one input request per cycle while the two-group token queue has room; the
// output side moves one token per cycle while m_axis_tready is high, sending an item's tokens in turn.
// All lexing of one item happens in a single pass between the input register and
// the token queue. Reset (synchronous, active low) empties both and sets offset 0.
module css_token_lexer_top
    import css_lex_pkg::*;
#(
    parameter int OFFSET_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // text_byte
    input  logic [0:0]    s_axis_tuser,   // end_marker
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [111:0]  m_axis_tdata,   // token_kind, value_start, value_end,
                                          // unit_offset, delim_byte, zero fill
    output logic          m_axis_tlast    // last_of_run
);

    localparam int OB = OFFSET_BITS;

    // Input register.
    logic          r_in_vld;
    logic [7:0]    r_in_byte;
    logic          r_in_end;

    // Lexer state.
    t_ctl          r_ctl;
    logic [OB-1:0] r_tb;
    logic [OB-1:0] r_ub;
    logic [OB-1:0] r_pos;

    logic          room;
    logic          proceed;
    logic          push;
    t_bundle       bundle;
    t_tok          q_tok;
    logic          q_last;

    // Step chain signals.
    t_ctl          s_ctl_in  [4];
    logic [OB-1:0] s_tb_in   [4];
    logic [OB-1:0] s_ub_in   [4];
    logic [8:0]    s_b       [4];
    logic [OB-1:0] s_p       [4];
    logic          s_run     [4];
    t_ctl          s_ctl_out [4];
    logic [OB-1:0] s_tb_out  [4];
    logic [OB-1:0] s_ub_out  [4];
    logic          s_emit    [4];
    t_tok          s_tok     [4];
    logic          s_cont    [4];

    t_ctl          ctl_str;
    logic          str_emit;
    t_tok          str_tok;
    t_tok          eof_tok;
    logic          flush_cmt;
    logic [OB-1:0] pos_m1;
    logic          cand_v [6];
    t_tok          cand_t [6];
    logic [2:0]    k;

    assign proceed       = r_in_vld && room;
    assign s_axis_tready = !r_in_vld || proceed;
    assign pos_m1        = r_pos - OB'(1);
    assign flush_cmt     = r_in_end && (r_ctl.mode == M_COMMENT);

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_end  <= s_axis_tuser[0];
        end
    end

    // Inputs of the first step: at an end marker inside a comment it replays the held last comment byte.
    always_comb begin
        s_ctl_in[0] = r_ctl;
        s_tb_in[0]  = r_tb;
        s_ub_in[0]  = r_ub;
        if (r_in_end) begin
            s_b[0]   = {1'b0, r_ctl.la0};
            s_p[0]   = pos_m1;
            s_run[0] = flush_cmt && r_ctl.la_vld;
            if (flush_cmt) begin
                s_ctl_in[0].mode   = M_IDLE;
                s_ctl_in[0].la_vld = 1'b0;
            end
        end else begin
            s_b[0]   = {1'b0, r_in_byte};
            s_p[0]   = r_pos;
            s_run[0] = 1'b1;
        end
    end

    // An open string at the end marker runs to the end of the text.
    always_comb begin
        ctl_str  = s_ctl_out[0];
        str_emit = 1'b0;
        str_tok  = '0;
        if (r_in_end && s_ctl_out[0].mode == M_STRING) begin
            str_emit     = 1'b1;
            str_tok.kind = K_STRING;
            str_tok.vs   = 32'(s_tb_out[0]);
            str_tok.ve   = 32'(r_pos);
            str_tok.uo   = 32'(r_pos);
            ctl_str.mode = M_IDLE;
        end
    end

    // Inputs of the later steps.
    for (genvar g = 1; g < 4; g++) begin : g_link
        if (g == 1) begin : g_after_first
            assign s_ctl_in[g] = ctl_str;
            assign s_run[g]    = r_in_end || (s_run[0] && s_cont[0]);
        end else begin : g_after_chain
            assign s_ctl_in[g] = s_ctl_out[g-1];
            assign s_run[g]    = s_run[g-1] && s_cont[g-1];
        end
        assign s_tb_in[g] = s_tb_out[g-1];
        assign s_ub_in[g] = s_ub_out[g-1];
        assign s_b[g]     = r_in_end ? SYM_END : {1'b0, r_in_byte};
        assign s_p[g]     = r_pos;
    end

    for (genvar g = 0; g < 4; g++) begin : g_step
        css_lex_phase #(
            .OB (OB)
        ) u_phase (
            .i_run  (s_run[g]),
            .i_ctl  (s_ctl_in[g]),
            .i_tb   (s_tb_in[g]),
            .i_ub   (s_ub_in[g]),
            .i_b    (s_b[g]),
            .i_p    (s_p[g]),
            .o_ctl  (s_ctl_out[g]),
            .o_tb   (s_tb_out[g]),
            .o_ub   (s_ub_out[g]),
            .o_emit (s_emit[g]),
            .o_tok  (s_tok[g]),
            .o_cont (s_cont[g])
        );
    end

    // End-of-text token.
    always_comb begin
        eof_tok      = '0;
        eof_tok.kind = K_EOF;
        eof_tok.vs   = 32'(r_pos);
        eof_tok.ve   = 32'(r_pos);
        eof_tok.uo   = 32'(r_pos);
    end

    // Pack the emitted tokens in order into one group.
    always_comb begin
        cand_v[0] = s_emit[0];
        cand_t[0] = s_tok[0];
        cand_v[1] = str_emit;
        cand_t[1] = str_tok;
        cand_v[2] = s_emit[1];
        cand_t[2] = s_tok[1];
        cand_v[3] = s_emit[2];
        cand_t[3] = s_tok[2];
        cand_v[4] = s_emit[3];
        cand_t[4] = s_tok[3];
        cand_v[5] = r_in_end;
        cand_t[5] = eof_tok;
        bundle    = '0;
        k         = 3'd0;
        for (int i = 0; i < 6; i++) begin
            if (cand_v[i] && k != 3'd4) begin
                bundle.tok[k[1:0]] = cand_t[i];
                k                  = k + 3'd1;
            end
        end
        bundle.cnt = k;
    end

    assign push = proceed && (bundle.cnt != 3'd0);

    // State update; the end marker starts a fresh text.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '{mode: M_IDLE, la_vld: 1'b0, la0: 8'h00, quote: 8'h00, esc: 1'b0};
            r_tb  <= '0;
            r_ub  <= '0;
            r_pos <= '0;
        end else if (proceed) begin
            if (r_in_end) begin
                r_ctl <= '{mode: M_IDLE, la_vld: 1'b0, la0: 8'h00, quote: 8'h00, esc: 1'b0};
                r_tb  <= '0;
                r_ub  <= '0;
                r_pos <= '0;
            end else begin
                r_ctl <= s_ctl_out[3];
                r_tb  <= s_tb_out[3];
                r_ub  <= s_ub_out[3];
                r_pos <= r_pos + OB'(1);
            end
        end
    end

    css_lex_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (bundle),
        .o_room   (room),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_tok    (q_tok),
        .o_last   (q_last)
    );

    assign m_axis_tdata = {3'b000, q_tok.delim, q_tok.uo, q_tok.ve, q_tok.vs, q_tok.kind};
    assign m_axis_tlast = q_last;

    a_pos_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proceed && r_in_end |=> r_pos == '0)
        else $error("offset not cleared after end marker");

    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proceed && !r_in_end |=> r_pos == $past(r_pos) + OB'(1))
        else $error("offset did not advance by one byte");

    a_idle_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proceed && r_in_end |=> r_ctl.mode == M_IDLE && !r_ctl.la_vld)
        else $error("lexer not idle after end marker");

endmodule
